// ----- rtl/core/hapk_pkg.sv -----
// Shared types, constants and helpers for the peer keepalive block.
package hapk_pkg;

    localparam int TICK_BITS  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SEQ_W      = 32;

    typedef logic [TICK_BITS-1:0] tick_t;

    typedef enum logic [2:0] {
        FUNC_TICK       = 3'd0,
        FUNC_REQUEST    = 3'd1,
        FUNC_RESPONSE   = 3'd2,
        FUNC_HELLO      = 3'd3,
        FUNC_HELLO_RESP = 3'd4,
        FUNC_HEARTBEAT  = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ACT_HELLO       = 3'd0,
        ACT_HEARTBEAT   = 3'd1,
        ACT_HELLO_REPLY = 3'd2,
        ACT_RESPONSE    = 3'd3,
        ACT_RELEASE     = 3'd4,
        ACT_LINK_UP     = 3'd5,
        ACT_LINK_DOWN   = 3'd6,
        ACT_SNAPSHOT    = 3'd7
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_CONFIGURED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_PER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HELLO_PER       = 3'd4;

    typedef struct packed {
        logic [2:0]       func;
        logic [SEQ_W-1:0] rx_seq;
    } req_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic        enable;
        logic        peer_configured;
        logic [15:0] heartbeat_period;
        logic [7:0]  max_missed_beats;
        logic [15:0] hello_retry_period;
    } cfg_t;

    typedef struct packed {
        func_t            op;
        logic [SEQ_W-1:0] seq;
    } cmd_t;

    // True when a is at or after b on the wrapping tick clock.
    function automatic logic at_or_after(tick_t a, tick_t b);
        tick_t diff;
        diff = a - b;
        return ~diff[TICK_BITS-1];
    endfunction

endpackage

// ----- rtl/core/hapk_front.sv -----
// Front end: accepts transactions, drops those with no effect and queues commands.
module hapk_front (
    input  logic          clk,
    input  logic          rst_n,
    input  hapk_pkg::cfg_t cfg,
    input  logic          req_valid,
    output logic          req_ready,
    input  hapk_pkg::req_t req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output hapk_pkg::cmd_t cmd
);
    import hapk_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       push;
    logic       pop;
    cmd_t       new_cmd;

    always_comb
    begin
        keep = 1'b0;
        if (cfg.enable)
        begin
            if (req.func == FUNC_TICK)
            begin
                keep = 1'b1;
            end
            else if (cfg.peer_configured &&
                     (req.func inside {FUNC_REQUEST, FUNC_RESPONSE, FUNC_HELLO,
                                       FUNC_HELLO_RESP, FUNC_HEARTBEAT}))
            begin
                keep = 1'b1;
            end
        end
        new_cmd.op  = func_t'(req.func);
        new_cmd.seq = req.rx_seq;
    end

    assign req_ready = (count_reg != 2'd2);
    assign push      = req_valid && req_ready && keep;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- rtl/core/hapk_back.sv -----
// Back end: keepalive state, timers and the result queue.
module hapk_back (
    input  logic          clk,
    input  logic          rst_n,
    input  hapk_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  hapk_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output hapk_pkg::rsp_t rsp
);
    import hapk_pkg::*;

    tick_t             clock_reg, clock_next;
    logic              connected_reg, connected_next;
    tick_t             next_hello_reg, next_hello_next;
    tick_t             last_sent_reg, last_sent_next;
    tick_t             last_heard_reg, last_heard_next;
    logic [15:0]       attempts_reg, attempts_next;
    logic              snap_reg, snap_next;
    logic [SEQ_W-1:0]  beat_seq_reg, beat_seq_next;

    rsp_t              res_q_reg [4];
    logic [1:0]        res_wr_reg, res_wr_next;
    logic [1:0]        res_rd_reg, res_rd_next;
    logic [2:0]        res_count_reg, res_count_next;

    logic              take;
    logic              pop;
    logic [23:0]       timeout_prod;
    tick_t             now;
    tick_t             limit;
    logic              cand_v [4];
    action_t           cand_a [4];
    logic [SEQ_W-1:0]  cand_s [4];
    rsp_t              r0, r1;
    logic [1:0]        n_res;
    logic [1:0]        n_push;

    assign cmd_ready    = (res_count_reg <= 3'd2);
    assign take         = cmd_valid && cmd_ready;
    assign timeout_prod = {8'd0, cfg.heartbeat_period} * {16'd0, cfg.max_missed_beats};

    always_comb
    begin
        clock_next      = clock_reg;
        connected_next  = connected_reg;
        next_hello_next = next_hello_reg;
        last_sent_next  = last_sent_reg;
        last_heard_next = last_heard_reg;
        attempts_next   = attempts_reg;
        snap_next       = snap_reg;
        beat_seq_next   = beat_seq_reg;
        now             = clock_reg;
        limit           = last_heard_reg + tick_t'(timeout_prod);
        for (int i = 0; i < 4; i++)
        begin
            cand_v[i] = 1'b0;
            cand_a[i] = ACT_HELLO;
            cand_s[i] = '0;
        end

        case (cmd.op)
            FUNC_TICK:
            begin
                now        = clock_reg + tick_t'(1);
                clock_next = now;
                if (cfg.peer_configured && !connected_reg && at_or_after(now, next_hello_reg))
                begin
                    cand_v[0] = 1'b1;
                    cand_a[0] = ACT_HELLO;
                    if (attempts_reg != 16'hFFFF)
                    begin
                        attempts_next = attempts_reg + 16'd1;
                    end
                    next_hello_next = now + tick_t'(cfg.hello_retry_period);
                end
                if (connected_reg && cfg.peer_configured)
                begin
                    if (at_or_after(now, last_sent_reg + tick_t'(cfg.heartbeat_period)))
                    begin
                        beat_seq_next  = beat_seq_reg + SEQ_W'(1);
                        cand_v[1]      = 1'b1;
                        cand_a[1]      = ACT_HEARTBEAT;
                        cand_s[1]      = beat_seq_next;
                        last_sent_next = now;
                    end
                    if (at_or_after(now, limit) && (now != limit))
                    begin
                        cand_v[2]       = 1'b1;
                        cand_a[2]       = ACT_LINK_DOWN;
                        connected_next  = 1'b0;
                        attempts_next   = 16'd0;
                        next_hello_next = now;
                        snap_next       = 1'b0;
                    end
                end
                if (snap_next)
                begin
                    snap_next = 1'b0;
                    cand_v[3] = 1'b1;
                    cand_a[3] = ACT_SNAPSHOT;
                end
            end
            FUNC_REQUEST:
            begin
                cand_v[0] = 1'b1;
                cand_a[0] = ACT_RESPONSE;
                cand_s[0] = cmd.seq;
            end
            FUNC_RESPONSE:
            begin
                cand_v[0] = 1'b1;
                cand_a[0] = ACT_RELEASE;
                cand_s[0] = cmd.seq;
            end
            FUNC_HELLO:
            begin
                cand_v[0]       = 1'b1;
                cand_a[0]       = ACT_HELLO_REPLY;
                attempts_next   = 16'd0;
                last_heard_next = now;
            end
            FUNC_HELLO_RESP:
            begin
                connected_next  = 1'b1;
                cand_v[0]       = 1'b1;
                cand_a[0]       = ACT_LINK_UP;
                attempts_next   = 16'd0;
                last_heard_next = now;
                snap_next       = 1'b1;
            end
            FUNC_HEARTBEAT:
            begin
                last_heard_next = now;
            end
            default:
            begin
            end
        endcase

        // At most two results are kept, in the order they were raised.
        n_res = 2'd0;
        r0    = '0;
        r1    = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i])
            begin
                if (n_res == 2'd0)
                begin
                    r0.action = cand_a[i];
                    r0.seq    = cand_s[i];
                    n_res     = 2'd1;
                end
                else if (n_res == 2'd1)
                begin
                    r1.action = cand_a[i];
                    r1.seq    = cand_s[i];
                    n_res     = 2'd2;
                end
            end
        end
        r0.last = (n_res == 2'd1);
        r1.last = 1'b1;
    end

    assign rsp_valid = (res_count_reg != 3'd0);
    assign rsp       = res_q_reg[res_rd_reg];
    assign pop       = rsp_valid && rsp_ready;
    assign n_push    = take ? n_res : 2'd0;

    always_comb
    begin
        res_wr_next    = res_wr_reg + n_push;
        res_rd_next    = res_rd_reg + {1'b0, pop};
        res_count_next = res_count_reg + {1'b0, n_push} - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg      <= '0;
            connected_reg  <= 1'b0;
            next_hello_reg <= '0;
            last_sent_reg  <= '0;
            last_heard_reg <= '0;
            attempts_reg   <= 16'd0;
            snap_reg       <= 1'b0;
            beat_seq_reg   <= '0;
            res_wr_reg     <= 2'd0;
            res_rd_reg     <= 2'd0;
            res_count_reg  <= 3'd0;
        end
        else
        begin
            if (take)
            begin
                clock_reg      <= clock_next;
                connected_reg  <= connected_next;
                next_hello_reg <= next_hello_next;
                last_sent_reg  <= last_sent_next;
                last_heard_reg <= last_heard_next;
                attempts_reg   <= attempts_next;
                snap_reg       <= snap_next;
                beat_seq_reg   <= beat_seq_next;
            end
            res_wr_reg    <= res_wr_next;
            res_rd_reg    <= res_rd_next;
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            res_q_reg[res_wr_reg] <= r0;
        end
        if (n_push == 2'd2)
        begin
            res_q_reg[res_wr_reg + 2'd1] <= r1;
        end
    end

endmodule

// ----- rtl/core/ha_peer_keepalive_fsm_core.sv -----
// Top level of the peer keepalive block: configuration registers and the two halves.
//
// Requests arrive on req_valid/req_ready with req carrying func and rx_seq; each
// accepted transaction advances the tick clock or reports a received message.
// Results leave on rsp_valid/rsp_ready with rsp carrying action, seq and last;
// last marks the final result of one request, which yields none, one or two.
// Configuration is written through cfg_we, cfg_idx and cfg_data while idle.
// A request is accepted every cycle while the two-entry command queue has room.
// Unless stalled, the back end executes one command per cycle; a result passes the
// command queue and then the result queue registers, and a two-result request gives
// its results one after the other. The back end takes a command only while the
// four-entry result queue has room for two results, so a stalled receiver fills
// the result queue, then the command queue, then req_ready falls. Nothing is lost.
// Reset clears all state and both queues and loads the configuration defaults:
// block disabled, peer not configured, heartbeat period 10, three missed beats
// allowed and hello retry period 5.
module ha_peer_keepalive_fsm_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hapk_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [hapk_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  hapk_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output hapk_pkg::rsp_t                   rsp
);
    import hapk_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_ENABLE:          cfg_next.enable             = cfg_data[0];
                CFG_PEER_CONFIGURED: cfg_next.peer_configured    = cfg_data[0];
                CFG_HEARTBEAT_PER:   cfg_next.heartbeat_period   = cfg_data;
                CFG_MAX_MISSED:      cfg_next.max_missed_beats   = cfg_data[7:0];
                CFG_HELLO_PER:       cfg_next.hello_retry_period = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable             <= 1'b0;
            cfg_reg.peer_configured    <= 1'b0;
            cfg_reg.heartbeat_period   <= 16'd10;
            cfg_reg.max_missed_beats   <= 8'd3;
            cfg_reg.hello_retry_period <= 16'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hapk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    hapk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/core/hapk_checker.sv -----
// Port-level checks for the peer keepalive block and their binding to the top level.
module hapk_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_ready,
    input  hapk_pkg::req_t                   req,
    input  logic                             rsp_valid,
    input  logic                             rsp_ready,
    input  hapk_pkg::rsp_t                   rsp
);
    import hapk_pkg::*;

    a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.action != ACT_HEARTBEAT && rsp.action != ACT_RESPONSE &&
        rsp.action != ACT_RELEASE |-> rsp.seq == '0)
        else $error("seq is not zero for an action that carries none");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.action == ACT_HELLO_REPLY || rsp.action == ACT_RESPONSE ||
        rsp.action == ACT_RELEASE || rsp.action == ACT_LINK_UP) |-> rsp.last)
        else $error("a message reply is not marked as the final result");

    a_final_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.action == ACT_SNAPSHOT || rsp.action == ACT_LINK_DOWN)
        |-> rsp.last)
        else $error("snapshot or link down is followed by another result");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result transaction changed or vanished");

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("stalled request transaction changed or vanished");

endmodule

bind ha_peer_keepalive_fsm_core hapk_checker u_hapk_checker (.*);

// ----- tb/ha_peer_keepalive_fsm_core_tb.sv -----
// Self-checking testbench for the peer keepalive core, with its own predictor of every result.
`timescale 1ns / 100ps

module ha_peer_keepalive_fsm_core_tb;
    import hapk_pkg::*;

    localparam logic [2:0] FUNC_SPARE_LOW  = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HIGH = 3'd7;
    localparam tick_t HALF_RANGE     = tick_t'(1) << (TICK_BITS - 1);
    localparam int    SETTLE_CYCLES  = 16;
    localparam int    WATCHDOG_LIMIT = 3000;
    localparam int    HOLD_CYCLES    = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;

    // Configuration as the block holds it.
    bit          cfg_enable = 1'b0;
    bit          cfg_peer = 1'b0;
    logic [15:0] cfg_beat_period = 16'd10;
    logic [7:0]  cfg_missed = 8'd3;
    logic [15:0] cfg_hello_period = 16'd5;

    // Liveness state of the peer link.
    tick_t       clock_now = '0;
    bit          peer_up = 1'b0;
    tick_t       hello_due = '0;
    tick_t       beat_sent_at = '0;
    tick_t       heard_at = '0;
    logic [15:0] hello_tries = '0;
    bit          snapshot_armed = 1'b0;
    logic [31:0] beat_number = '0;

    rsp_t        step_actions[$];
    rsp_t        awaited_actions[$];
    rsp_t        oldest;
    int          mismatches = 0;
    int          sender_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_left = 0;
    int          stuck_cycles = 0;

    ha_peer_keepalive_fsm_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit not_before(tick_t a, tick_t b);
        tick_t gap;
        gap = a - b;
        return gap < HALF_RANGE;
    endfunction

    function automatic void note_action(action_t act, logic [SEQ_W-1:0] value);
        rsp_t r;
        if (step_actions.size() >= 2)
        begin
            return;
        end
        r.action = act;
        r.seq    = value;
        r.last   = 1'b0;
        step_actions.push_back(r);
    endfunction

    function automatic void predict_actions(req_t item);
        tick_t now;
        tick_t deadline;
        step_actions.delete();
        if (!cfg_enable)
        begin
            return;
        end
        if (item.func == FUNC_TICK)
        begin
            clock_now = clock_now + 1'b1;
            now = clock_now;
            if (cfg_peer && !peer_up && not_before(now, hello_due))
            begin
                note_action(ACT_HELLO, '0);
                if (hello_tries != 16'hFFFF)
                begin
                    hello_tries = hello_tries + 1'b1;
                end
                hello_due = now + tick_t'(cfg_hello_period);
            end
            if (peer_up && cfg_peer)
            begin
                if (not_before(now, beat_sent_at + tick_t'(cfg_beat_period)))
                begin
                    beat_number = beat_number + 1'b1;
                    note_action(ACT_HEARTBEAT, beat_number);
                    beat_sent_at = now;
                end
                deadline = heard_at + tick_t'(cfg_beat_period) * tick_t'(cfg_missed);
                if (not_before(now, deadline) && now != deadline)
                begin
                    note_action(ACT_LINK_DOWN, '0);
                    peer_up        = 1'b0;
                    hello_tries    = '0;
                    hello_due      = now;
                    snapshot_armed = 1'b0;
                end
            end
            if (snapshot_armed)
            begin
                snapshot_armed = 1'b0;
                note_action(ACT_SNAPSHOT, '0);
            end
        end
        else if (cfg_peer)
        begin
            case (item.func)
                FUNC_REQUEST:
                begin
                    note_action(ACT_RESPONSE, item.rx_seq);
                end
                FUNC_RESPONSE:
                begin
                    note_action(ACT_RELEASE, item.rx_seq);
                end
                FUNC_HELLO:
                begin
                    note_action(ACT_HELLO_REPLY, '0);
                    hello_tries = '0;
                    heard_at    = clock_now;
                end
                FUNC_HELLO_RESP:
                begin
                    peer_up = 1'b1;
                    note_action(ACT_LINK_UP, '0);
                    hello_tries    = '0;
                    heard_at       = clock_now;
                    snapshot_armed = 1'b1;
                end
                FUNC_HEARTBEAT:
                begin
                    heard_at = clock_now;
                end
                default:
                begin
                end
            endcase
        end
        if (step_actions.size() != 0)
        begin
            step_actions[step_actions.size() - 1].last = 1'b1;
        end
        foreach (step_actions[i])
        begin
            awaited_actions.push_back(step_actions[i]);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_actions.size() == 0)
            begin
                $error("unexpected result: action %0d seq %0h last %0b",
                       rsp.action, rsp.seq, rsp.last);
                mismatches++;
            end
            else
            begin
                oldest = awaited_actions.pop_front();
                if (rsp.action !== oldest.action)
                begin
                    $error("action: expected %0d, got %0d", oldest.action, rsp.action);
                    mismatches++;
                end
                if (rsp.seq !== oldest.seq)
                begin
                    $error("seq: expected %0h, got %0h", oldest.seq, rsp.seq);
                    mismatches++;
                end
                if (rsp.last !== oldest.last)
                begin
                    $error("last: expected %0b, got %0b", oldest.last, rsp.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[ha_peer_keepalive_fsm_core] ERROR");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_item(logic [2:0] code, logic [SEQ_W-1:0] value);
        int   gap;
        req_t item;
        gap = 0;
        item.func   = code;
        item.rx_seq = value;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predict_actions(item);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (awaited_actions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic set_config(bit en, bit peer, logic [15:0] beat, logic [7:0] missed,
                              logic [15:0] hello);
        wait_idle();
        write_reg(CFG_ENABLE, {15'd0, en});
        write_reg(CFG_PEER_CONFIGURED, {15'd0, peer});
        write_reg(CFG_HEARTBEAT_PER, beat);
        write_reg(CFG_MAX_MISSED, {8'd0, missed});
        write_reg(CFG_HELLO_PER, hello);
        cfg_we <= 1'b0;
        cfg_enable       = en;
        cfg_peer         = peer;
        cfg_beat_period  = beat;
        cfg_missed       = missed;
        cfg_hello_period = hello;
    endtask

    function automatic logic [15:0] pick_period(int unsigned small_top, logic [15:0] top);
        int unsigned roll;
        roll = $urandom_range(19);
        if (roll == 0)
        begin
            return '0;
        end
        if (roll == 1)
        begin
            return top;
        end
        return 16'($urandom_range(small_top, 1));
    endfunction

    task automatic test_disabled_block();
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        send_item(FUNC_TICK, 32'hFFFF_FFFF);
        send_item(FUNC_REQUEST, 32'hFFFF_FFFF);
        send_item(FUNC_HELLO_RESP, '0);
        set_config(1'b1, 1'b0, 16'd10, 8'd3, 16'd5);
        send_item(FUNC_TICK, '0);
        send_item(FUNC_REQUEST, 32'h1234_5678);
        send_item(FUNC_HELLO, '0);
    endtask

    task automatic test_link_lifecycle();
        set_config(1'b1, 1'b1, 16'd2, 8'd1, 16'd3);
        send_item(FUNC_TICK, '0);
        send_item(FUNC_TICK, '0);
        send_item(FUNC_TICK, '0);
        send_item(FUNC_HELLO, '0);
        send_item(FUNC_HELLO_RESP, '0);
        send_item(FUNC_TICK, '0);
        send_item(FUNC_REQUEST, '0);
        send_item(FUNC_REQUEST, 32'hFFFF_FFFF);
        send_item(FUNC_RESPONSE, 32'h5A5A_A5A5);
        send_item(FUNC_HEARTBEAT, '0);
        send_item(FUNC_SPARE_LOW, 32'hFFFF_FFFF);
        send_item(FUNC_SPARE_HIGH, 32'hFFFF_FFFF);
        send_item(FUNC_HELLO_RESP, '0);
        repeat (4) send_item(FUNC_TICK, '0);
    endtask

    task automatic test_zero_periods();
        set_config(1'b1, 1'b1, 16'd0, 8'd0, 16'd0);
        send_item(FUNC_TICK, '0);
        send_item(FUNC_TICK, '0);
        send_item(FUNC_HELLO_RESP, '0);
        send_item(FUNC_TICK, '0);
        send_item(FUNC_HELLO_RESP, '0);
        set_config(1'b1, 1'b0, 16'd0, 8'd0, 16'd0);
        send_item(FUNC_TICK, '0);
        set_config(1'b1, 1'b1, 16'd0, 8'd0, 16'd0);
        send_item(FUNC_TICK, '0);
    endtask

    task automatic test_extreme_periods();
        set_config(1'b1, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_item(FUNC_HELLO_RESP, '0);
        send_item(FUNC_TICK, '0);
        send_item(FUNC_TICK, '0);
    endtask

    task automatic test_random_traffic(int sender_pct, int rx_pct, int count);
        int unsigned roll;
        logic [2:0]  code;
        logic [15:0] missed_pick;
        sender_idle_pct = sender_pct;
        rx_stall_pct    = rx_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
            begin
                missed_pick = pick_period(4, 16'd255);
                set_config($urandom_range(9) != 0, $urandom_range(7) != 0,
                           pick_period(8, 16'hFFFF), missed_pick[7:0],
                           pick_period(6, 16'hFFFF));
            end
            roll = $urandom_range(99);
            if (roll < 50)
                code = FUNC_TICK;
            else if (roll < 60)
                code = FUNC_REQUEST;
            else if (roll < 70)
                code = FUNC_RESPONSE;
            else if (roll < 75)
                code = FUNC_HELLO;
            else if (roll < 83)
                code = FUNC_HELLO_RESP;
            else if (roll < 97)
                code = FUNC_HEARTBEAT;
            else if (roll < 98)
                code = FUNC_SPARE_LOW;
            else
                code = FUNC_SPARE_HIGH;
            send_item(code, $urandom());
        end
    endtask

    task automatic test_result_backpressure();
        set_config(1'b1, 1'b1, 16'd10, 8'd3, 16'd5);
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        hold_left <= HOLD_CYCLES;
        repeat (40) send_item(FUNC_REQUEST, $urandom());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disabled_block();
        test_link_lifecycle();
        test_zero_periods();
        test_extreme_periods();
        test_random_traffic(0, 0, 300);
        test_random_traffic(79, 0, 250);
        test_random_traffic(0, 79, 250);
        test_random_traffic(11, 11, 250);
        test_result_backpressure();
        wait_idle();
        if (mismatches == 0)
        begin
            $display("[ha_peer_keepalive_fsm_core] OK");
        end
        else
        begin
            $display("[ha_peer_keepalive_fsm_core] ERROR");
        end
        $finish;
    end

endmodule
